// File: rtl/gdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid DDA raycaster package
// Shared widths, register indexes, datapath opcodes and control structs.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam int unsigned MAP_SIZE   = 32;
  localparam int unsigned MAP_AW     = 5;
  localparam int unsigned MAP_DEPTH  = MAP_SIZE * MAP_SIZE;
  localparam int unsigned MAP_IW     = 2 * MAP_AW;
  localparam int unsigned CELL_W     = 4;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned SCREEN_H   = 512;
  localparam int unsigned STEP_LIMIT = 2 * MAP_SIZE + 2;
  localparam int unsigned STEP_CW    = 7;

  localparam int unsigned POS_W   = 21;
  localparam int unsigned DIR_W   = 18;
  localparam int unsigned RAY_W   = 21;
  localparam int unsigned DELTA_W = 34;
  localparam int unsigned SDIST_W = 41;
  localparam int unsigned DIST_W  = 22;
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned HL_W    = 11;
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned TEX_W   = 4;
  localparam int unsigned COL_W   = 10;

  // Shared restoring divider.
  localparam int unsigned DIV_NW  = 42;
  localparam int unsigned DIV_DW  = 22;
  localparam int unsigned DIV_CW  = 6;

  // Shared multiplier.
  localparam int unsigned MUL_AW  = 35;
  localparam int unsigned MUL_BW  = 22;
  localparam int unsigned MUL_PW  = MUL_AW + MUL_BW;

  typedef enum logic [2:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_MULX,
    OP_RAYX,
    OP_MULY,
    OP_RAYY,
    OP_DX,
    OP_DY,
    OP_MSX,
    OP_SX,
    OP_MSY,
    OP_SY,
    OP_STEP,
    OP_NUM,
    OP_DIST,
    OP_HLINE,
    OP_MOFF,
    OP_OFF,
    OP_FIN,
    OP_FNH
  } dp_op_e;

  typedef enum logic [2:0] {
    DS_DX,
    DS_DY,
    DS_DIST,
    DS_HLINE,
    DS_OFF
  } div_sel_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MULX,
    ST_RAYX,
    ST_MULY,
    ST_RAYY,
    ST_DXG,
    ST_DXW,
    ST_DYG,
    ST_DYW,
    ST_MSX,
    ST_SX,
    ST_MSY,
    ST_SY,
    ST_STEP,
    ST_TEST,
    ST_NUM,
    ST_DDG,
    ST_DDW,
    ST_HG,
    ST_HW,
    ST_MOFF,
    ST_OG,
    ST_OW,
    ST_FIN,
    ST_FNH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e   op;
    logic     div_start;
    div_sel_e div_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_busy;
    logic div_done;
    logic coord_out;
    logic cell_hit;
    logic step_limit;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/gdr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdr_ram #(
  parameter int unsigned WIDTH = gdr_pkg::CELL_W,
  parameter int unsigned DEPTH = gdr_pkg::MAP_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gdr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gdr_pkg::DIV_NW-1:0]  dividend_i,
  input  logic [gdr_pkg::DIV_DW-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [gdr_pkg::DIV_NW-1:0]  quotient_o
);

  localparam int unsigned NW = gdr_pkg::DIV_NW;
  localparam int unsigned DW = gdr_pkg::DIV_DW;
  localparam int unsigned CW = gdr_pkg::DIV_CW;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dsr_q, dsr_d;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DW'(trial - {1'b0, dsr_q}) : DW'(trial);
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/gdr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raycaster datapath
// Map memory, shared multiplier and divider, DDA walk registers and result.
// ----------------------------------------------------------------------------
module gdr_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gdr_pkg::dp_cmd_t                    cmd_i,
  output gdr_pkg::dp_stat_t                   st_o,
  input  logic [gdr_pkg::POS_W-1:0]           pos_x_i,
  input  logic [gdr_pkg::POS_W-1:0]           pos_y_i,
  input  logic signed [gdr_pkg::DIR_W-1:0]    dir_x_i,
  input  logic signed [gdr_pkg::DIR_W-1:0]    dir_y_i,
  input  logic signed [gdr_pkg::DIR_W-1:0]    plane_x_i,
  input  logic signed [gdr_pkg::DIR_W-1:0]    plane_y_i,
  input  logic                                in_accept_i,
  input  logic                                in_mode_i,
  input  logic [gdr_pkg::MAP_AW-1:0]          cell_x_i,
  input  logic [gdr_pkg::MAP_AW-1:0]          cell_y_i,
  input  logic [gdr_pkg::CELL_W-1:0]          cell_value_i,
  input  logic [gdr_pkg::COL_W-1:0]           column_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gdr_pkg::ROW_W-1:0]           draw_start_o,
  output logic [gdr_pkg::ROW_W-1:0]           draw_end_o,
  output logic [gdr_pkg::TEX_W-1:0]           texture_index_o,
  output logic                                hit_side_o,
  output logic [gdr_pkg::POS_W-1:0]           wall_coordinate_o,
  output logic [gdr_pkg::DIST_W-1:0]          perpendicular_distance_o,
  output logic                                no_hit_o
);

  localparam int unsigned FB   = gdr_pkg::FRAC_BITS;
  localparam int unsigned PW   = gdr_pkg::POS_W;
  localparam int unsigned RW   = gdr_pkg::RAY_W;
  localparam int unsigned NUMW = gdr_pkg::NUM_W;
  localparam int unsigned CW   = gdr_pkg::MAP_AW + 2;
  localparam int unsigned NW   = gdr_pkg::DIV_NW;
  localparam int unsigned DW   = gdr_pkg::DIV_DW;
  localparam int unsigned SW   = gdr_pkg::SDIST_W;
  localparam int unsigned HW   = gdr_pkg::HL_W;
  localparam int unsigned ROWW = gdr_pkg::ROW_W;
  localparam int unsigned OFFW = NW + 2;
  localparam int unsigned HALF_H = gdr_pkg::SCREEN_H / 2;
  localparam logic signed [NW-1:0] RAY_HI = NW'((1 << (RW - 1)) - 1);
  localparam logic signed [NW-1:0] RAY_LO = -NW'(1 << (RW - 1));
  localparam logic [HW-1:0] HL_MAX = HW'(2 * gdr_pkg::SCREEN_H);
  localparam logic [PW-1:0] COORD_MAX = '1;
  localparam logic [gdr_pkg::DIST_W-1:0] DIST_MAX = '1;

  // Camera offset, ray, DDA and hit registers.
  logic signed [gdr_pkg::DIR_W-1:0]   cam_q;
  logic signed [RW-1:0]               rdx_q, rdy_q;
  logic [gdr_pkg::DELTA_W-1:0]        dx_q, dy_q;
  logic [SW-1:0]                      sx_q, sy_q;
  logic signed [CW-1:0]               mx_q, my_q, mx_nx, my_nx;
  logic                               side_q;
  logic [gdr_pkg::STEP_CW-1:0]        n_q;
  logic signed [NUMW-1:0]             num_q, num_d;
  logic signed [RW-1:0]               a_q, b_q;
  logic [PW-1:0]                      base_q;
  logic [gdr_pkg::DIST_W-1:0]         dist_q;
  logic [HW-1:0]                      hline_q;
  logic [PW-1:0]                      wall_q;
  logic signed [gdr_pkg::MUL_PW-1:0]  prod_q;
  logic [gdr_pkg::MAP_IW-1:0]         clr_q;

  // Output register.
  logic                               ovalid_q;
  logic [ROWW-1:0]                    ds_q, de_q;
  logic [gdr_pkg::TEX_W-1:0]          tex_q;
  logic                               oside_q;
  logic [PW-1:0]                      owall_q;
  logic [gdr_pkg::DIST_W-1:0]         odist_q;
  logic                               onohit_q;

  logic [RW-1:0]   abs_rdx, abs_rdy, abs_a, abs_b;
  logic [NUMW-1:0] abs_num;
  logic [FB:0]     frac_x, frac_y;

  assign abs_rdx = rdx_q[RW-1] ? RW'(-rdx_q) : RW'(rdx_q);
  assign abs_rdy = rdy_q[RW-1] ? RW'(-rdy_q) : RW'(rdy_q);
  assign abs_a   = a_q[RW-1] ? RW'(-a_q) : RW'(a_q);
  assign abs_b   = b_q[RW-1] ? RW'(-b_q) : RW'(b_q);
  assign abs_num = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);

  // Distance from the camera to the first grid line in each axis, in cells.
  assign frac_x = rdx_q[RW-1] ? {1'b0, pos_x_i[FB-1:0]}
                              : (FB+1)'((1 << FB) - pos_x_i[FB-1:0]);
  assign frac_y = rdy_q[RW-1] ? {1'b0, pos_y_i[FB-1:0]}
                              : (FB+1)'((1 << FB) - pos_y_i[FB-1:0]);

  // Shared multiplier.
  logic signed [gdr_pkg::MUL_AW-1:0] mul_a;
  logic signed [gdr_pkg::MUL_BW-1:0] mul_b;
  logic signed [gdr_pkg::MUL_PW-1:0] prod;

  always_comb begin
    case (cmd_i.op)
      gdr_pkg::OP_MULX: begin
        mul_a = gdr_pkg::MUL_AW'(plane_x_i);
        mul_b = gdr_pkg::MUL_BW'(cam_q);
      end
      gdr_pkg::OP_MULY: begin
        mul_a = gdr_pkg::MUL_AW'(plane_y_i);
        mul_b = gdr_pkg::MUL_BW'(cam_q);
      end
      gdr_pkg::OP_MSX: begin
        mul_a = $signed({1'b0, dx_q});
        mul_b = $signed(gdr_pkg::MUL_BW'(frac_x));
      end
      gdr_pkg::OP_MSY: begin
        mul_a = $signed({1'b0, dy_q});
        mul_b = $signed(gdr_pkg::MUL_BW'(frac_y));
      end
      gdr_pkg::OP_MOFF: begin
        mul_a = $signed(gdr_pkg::MUL_AW'(abs_num));
        mul_b = $signed(gdr_pkg::MUL_BW'(abs_a));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Ray component: direction plus plane times camera, quotient toward zero.
  logic signed [gdr_pkg::MUL_PW-1:0] prod_rnd;
  logic signed [NW-1:0]              ray_sum;
  logic signed [gdr_pkg::DIR_W-1:0]  dir_sel;
  logic signed [RW-1:0]              ray_sat;

  assign prod_rnd = prod_q + (prod_q[gdr_pkg::MUL_PW-1] ?
                    gdr_pkg::MUL_PW'((1 << FB) - 1) : '0);
  assign dir_sel  = (cmd_i.op == gdr_pkg::OP_RAYX) ? dir_x_i : dir_y_i;
  assign ray_sum  = NW'(prod_rnd >>> FB) + NW'(dir_sel);

  always_comb begin
    if (ray_sum < RAY_LO) begin
      ray_sat = RAY_LO[RW-1:0];
    end else if (ray_sum > RAY_HI) begin
      ray_sat = RAY_HI[RW-1:0];
    end else begin
      ray_sat = ray_sum[RW-1:0];
    end
  end

  // Shared divider.
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_busy, div_done;
  logic [NW-1:0] div_quo;

  always_comb begin
    case (cmd_i.div_sel)
      gdr_pkg::DS_DX: begin
        div_num = NW'(64'd1 << (2 * FB));
        div_den = DW'(abs_rdx);
      end
      gdr_pkg::DS_DY: begin
        div_num = NW'(64'd1 << (2 * FB));
        div_den = DW'(abs_rdy);
      end
      gdr_pkg::DS_DIST: begin
        div_num = NW'({abs_num, FB'(0)});
        div_den = DW'(abs_b);
      end
      gdr_pkg::DS_HLINE: begin
        div_num = NW'(64'(gdr_pkg::SCREEN_H) << FB);
        div_den = dist_q;
      end
      gdr_pkg::DS_OFF: begin
        div_num = prod_q[NW-1:0];
        div_den = DW'(abs_b);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  gdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // DDA step: advance along the axis whose side distance is smaller.
  logic step_x;
  assign step_x = sx_q < sy_q;
  assign mx_nx  = step_x ? (rdx_q[RW-1] ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
  assign my_nx  = step_x ? my_q : (rdy_q[RW-1] ? my_q - 1'b1 : my_q + 1'b1);

  logic coord_out;
  assign coord_out = mx_q < 0 || my_q < 0 ||
                     mx_q >= CW'(gdr_pkg::MAP_SIZE) || my_q >= CW'(gdr_pkg::MAP_SIZE);

  // Map memory, indexed x major.
  logic                          ram_we, ram_re;
  logic [gdr_pkg::MAP_IW-1:0]    ram_waddr, ram_raddr;
  logic [gdr_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;

  assign ram_we    = (cmd_i.op == gdr_pkg::OP_CLR) || (in_accept_i && !in_mode_i);
  assign ram_waddr = (cmd_i.op == gdr_pkg::OP_CLR) ? clr_q : {cell_x_i, cell_y_i};
  assign ram_wdata = (cmd_i.op == gdr_pkg::OP_CLR) ? '0 : cell_value_i;
  assign ram_re    = cmd_i.op == gdr_pkg::OP_STEP;
  assign ram_raddr = {mx_nx[gdr_pkg::MAP_AW-1:0], my_nx[gdr_pkg::MAP_AW-1:0]};

  gdr_ram #(
    .WIDTH (gdr_pkg::CELL_W),
    .DEPTH (gdr_pkg::MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Numerator of the perpendicular distance, from the crossed grid line.
  always_comb begin
    if (!side_q) begin
      num_d = $signed(NUMW'({mx_q[gdr_pkg::MAP_AW-1:0], FB'(0)}))
            - $signed(NUMW'(pos_x_i))
            + (rdx_q[RW-1] ? $signed(NUMW'(1 << FB)) : $signed(NUMW'(0)));
    end else begin
      num_d = $signed(NUMW'({my_q[gdr_pkg::MAP_AW-1:0], FB'(0)}))
            - $signed(NUMW'(pos_y_i))
            + (rdy_q[RW-1] ? $signed(NUMW'(1 << FB)) : $signed(NUMW'(0)));
    end
  end

  // Wall hit coordinate.
  logic                   off_neg;
  logic signed [OFFW-1:0] off_s, wall_s;
  assign off_neg = num_q[NUMW-1] ^ a_q[RW-1] ^ b_q[RW-1];
  assign off_s   = (b_q == '0) ? '0 :
                   (off_neg ? -$signed(OFFW'(div_quo)) : $signed(OFFW'(div_quo)));
  assign wall_s  = off_s + $signed(OFFW'(base_q));

  // Vertical span from the line height.
  logic [HW-2:0]   half;
  logic [ROWW-1:0] ds_val, de_val;
  assign half   = hline_q[HW-1:1];
  assign ds_val = (half > (HW-1)'(HALF_H)) ? '0 : ROWW'((HW-1)'(HALF_H) - half);
  assign de_val = ((HW)'(half) + HW'(HALF_H) >= HW'(gdr_pkg::SCREEN_H)) ?
                  ROWW'(gdr_pkg::SCREEN_H - 1) : ROWW'(half + (HW-1)'(HALF_H));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.op == gdr_pkg::OP_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.op == gdr_pkg::OP_FIN || cmd_i.op == gdr_pkg::OP_FNH) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i && in_mode_i) begin
      cam_q  <= $signed({1'b0, column_i, 7'b0}) - $signed(gdr_pkg::DIR_W'(1 << FB));
      mx_q   <= CW'(pos_x_i[PW-1:FB]);
      my_q   <= CW'(pos_y_i[PW-1:FB]);
      side_q <= 1'b0;
      n_q    <= '0;
    end
    case (cmd_i.op)
      gdr_pkg::OP_MULX, gdr_pkg::OP_MULY, gdr_pkg::OP_MSX,
      gdr_pkg::OP_MSY, gdr_pkg::OP_MOFF: begin
        prod_q <= prod;
      end
      gdr_pkg::OP_RAYX: begin
        rdx_q <= ray_sat;
      end
      gdr_pkg::OP_RAYY: begin
        rdy_q <= ray_sat;
      end
      gdr_pkg::OP_DX: begin
        if (div_done) begin
          dx_q <= (rdx_q == '0) ? gdr_pkg::DELTA_W'(64'd1 << (2 * FB + 1))
                                : gdr_pkg::DELTA_W'(div_quo);
        end
      end
      gdr_pkg::OP_DY: begin
        if (div_done) begin
          dy_q <= (rdy_q == '0) ? gdr_pkg::DELTA_W'(64'd1 << (2 * FB + 1))
                                : gdr_pkg::DELTA_W'(div_quo);
        end
      end
      gdr_pkg::OP_SX: begin
        sx_q <= SW'(prod_q >>> FB);
      end
      gdr_pkg::OP_SY: begin
        sy_q <= SW'(prod_q >>> FB);
      end
      gdr_pkg::OP_STEP: begin
        if (step_x) begin
          sx_q <= sx_q + SW'(dx_q);
        end else begin
          sy_q <= sy_q + SW'(dy_q);
        end
        mx_q   <= mx_nx;
        my_q   <= my_nx;
        side_q <= !step_x;
        n_q    <= n_q + 1'b1;
      end
      gdr_pkg::OP_NUM: begin
        num_q  <= num_d;
        a_q    <= side_q ? rdx_q : rdy_q;
        b_q    <= side_q ? rdy_q : rdx_q;
        base_q <= side_q ? pos_x_i : pos_y_i;
      end
      gdr_pkg::OP_DIST: begin
        if (div_done) begin
          if (b_q == '0 || div_quo > NW'(DIST_MAX)) begin
            dist_q <= DIST_MAX;
          end else begin
            dist_q <= div_quo[gdr_pkg::DIST_W-1:0];
          end
        end
      end
      gdr_pkg::OP_HLINE: begin
        if (div_done) begin
          if (dist_q == '0 || div_quo > NW'(HL_MAX)) begin
            hline_q <= HL_MAX;
          end else begin
            hline_q <= div_quo[HW-1:0];
          end
        end
      end
      gdr_pkg::OP_OFF: begin
        if (div_done) begin
          if (wall_s < 0) begin
            wall_q <= '0;
          end else if (wall_s > $signed(OFFW'(COORD_MAX))) begin
            wall_q <= COORD_MAX;
          end else begin
            wall_q <= wall_s[PW-1:0];
          end
        end
      end
      gdr_pkg::OP_FIN: begin
        ds_q     <= ds_val;
        de_q     <= de_val;
        tex_q    <= ram_rdata - 1'b1;
        oside_q  <= side_q;
        owall_q  <= wall_q;
        odist_q  <= dist_q;
        onohit_q <= 1'b0;
      end
      gdr_pkg::OP_FNH: begin
        ds_q     <= '0;
        de_q     <= '0;
        tex_q    <= '0;
        oside_q  <= side_q;
        owall_q  <= '0;
        odist_q  <= DIST_MAX;
        onohit_q <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign st_o.clr_done   = clr_q == gdr_pkg::MAP_IW'(gdr_pkg::MAP_DEPTH - 1);
  assign st_o.div_busy   = div_busy;
  assign st_o.div_done   = div_done;
  assign st_o.coord_out  = coord_out;
  assign st_o.cell_hit   = ram_rdata != '0;
  assign st_o.step_limit = n_q == gdr_pkg::STEP_CW'(gdr_pkg::STEP_LIMIT);
  assign st_o.out_free   = !ovalid_q || out_ready_i;

  assign out_valid_o              = ovalid_q;
  assign draw_start_o             = ds_q;
  assign draw_end_o               = de_q;
  assign texture_index_o          = tex_q;
  assign hit_side_o               = oside_q;
  assign wall_coordinate_o        = owall_q;
  assign perpendicular_distance_o = odist_q;
  assign no_hit_o                 = onohit_q;

endmodule

// File: rtl/gdr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raycaster controller
// Sequences map clearing, ray setup, the DDA walk and the result divisions.
// ----------------------------------------------------------------------------
module gdr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  output logic              in_ready_o,
  output gdr_pkg::dp_cmd_t  cmd_o,
  input  gdr_pkg::dp_stat_t st_i
);

  gdr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    cmd_o.op          = gdr_pkg::OP_NONE;
    cmd_o.div_start   = 1'b0;
    cmd_o.div_sel     = gdr_pkg::DS_DX;
    case (state_q)
      gdr_pkg::ST_CLEAR: begin
        cmd_o.op = gdr_pkg::OP_CLR;
        if (st_i.clr_done) begin
          state_d = gdr_pkg::ST_IDLE;
        end
      end
      gdr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_mode_i) begin
          state_d = gdr_pkg::ST_MULX;
        end
      end
      gdr_pkg::ST_MULX: begin
        cmd_o.op = gdr_pkg::OP_MULX;
        state_d  = gdr_pkg::ST_RAYX;
      end
      gdr_pkg::ST_RAYX: begin
        cmd_o.op = gdr_pkg::OP_RAYX;
        state_d  = gdr_pkg::ST_MULY;
      end
      gdr_pkg::ST_MULY: begin
        cmd_o.op = gdr_pkg::OP_MULY;
        state_d  = gdr_pkg::ST_RAYY;
      end
      gdr_pkg::ST_RAYY: begin
        cmd_o.op = gdr_pkg::OP_RAYY;
        state_d  = gdr_pkg::ST_DXG;
      end
      gdr_pkg::ST_DXG: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = gdr_pkg::DS_DX;
        state_d         = gdr_pkg::ST_DXW;
      end
      gdr_pkg::ST_DXW: begin
        cmd_o.op = gdr_pkg::OP_DX;
        if (st_i.div_done) begin
          state_d = gdr_pkg::ST_DYG;
        end
      end
      gdr_pkg::ST_DYG: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = gdr_pkg::DS_DY;
        state_d         = gdr_pkg::ST_DYW;
      end
      gdr_pkg::ST_DYW: begin
        cmd_o.op = gdr_pkg::OP_DY;
        if (st_i.div_done) begin
          state_d = gdr_pkg::ST_MSX;
        end
      end
      gdr_pkg::ST_MSX: begin
        cmd_o.op = gdr_pkg::OP_MSX;
        state_d  = gdr_pkg::ST_SX;
      end
      gdr_pkg::ST_SX: begin
        cmd_o.op = gdr_pkg::OP_SX;
        state_d  = gdr_pkg::ST_MSY;
      end
      gdr_pkg::ST_MSY: begin
        cmd_o.op = gdr_pkg::OP_MSY;
        state_d  = gdr_pkg::ST_SY;
      end
      gdr_pkg::ST_SY: begin
        cmd_o.op = gdr_pkg::OP_SY;
        state_d  = st_i.coord_out ? gdr_pkg::ST_FNH : gdr_pkg::ST_STEP;
      end
      gdr_pkg::ST_STEP: begin
        cmd_o.op = gdr_pkg::OP_STEP;
        state_d  = gdr_pkg::ST_TEST;
      end
      gdr_pkg::ST_TEST: begin
        if (st_i.coord_out) begin
          state_d = gdr_pkg::ST_FNH;
        end else if (st_i.cell_hit) begin
          state_d = gdr_pkg::ST_NUM;
        end else if (st_i.step_limit) begin
          state_d = gdr_pkg::ST_FNH;
        end else begin
          state_d = gdr_pkg::ST_STEP;
        end
      end
      gdr_pkg::ST_NUM: begin
        cmd_o.op = gdr_pkg::OP_NUM;
        state_d  = gdr_pkg::ST_DDG;
      end
      gdr_pkg::ST_DDG: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = gdr_pkg::DS_DIST;
        state_d         = gdr_pkg::ST_DDW;
      end
      gdr_pkg::ST_DDW: begin
        cmd_o.op = gdr_pkg::OP_DIST;
        if (st_i.div_done) begin
          state_d = gdr_pkg::ST_HG;
        end
      end
      gdr_pkg::ST_HG: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = gdr_pkg::DS_HLINE;
        state_d         = gdr_pkg::ST_HW;
      end
      gdr_pkg::ST_HW: begin
        cmd_o.op = gdr_pkg::OP_HLINE;
        if (st_i.div_done) begin
          state_d = gdr_pkg::ST_MOFF;
        end
      end
      gdr_pkg::ST_MOFF: begin
        cmd_o.op = gdr_pkg::OP_MOFF;
        state_d  = gdr_pkg::ST_OG;
      end
      gdr_pkg::ST_OG: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = gdr_pkg::DS_OFF;
        state_d         = gdr_pkg::ST_OW;
      end
      gdr_pkg::ST_OW: begin
        cmd_o.op = gdr_pkg::OP_OFF;
        if (st_i.div_done) begin
          state_d = gdr_pkg::ST_FIN;
        end
      end
      gdr_pkg::ST_FIN: begin
        if (st_i.out_free) begin
          cmd_o.op = gdr_pkg::OP_FIN;
          state_d  = gdr_pkg::ST_IDLE;
        end
      end
      gdr_pkg::ST_FNH: begin
        if (st_i.out_free) begin
          cmd_o.op = gdr_pkg::OP_FNH;
          state_d  = gdr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gdr_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !st_i.div_busy)
    else $error("divider started while busy");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == gdr_pkg::OP_FIN || cmd_o.op == gdr_pkg::OP_FNH) |-> st_i.out_free)
    else $error("result loaded over an untaken word");

  a_cast_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_mode_i) |=> !in_ready_o)
    else $error("input taken while a cast is in flight");

  a_no_input_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gdr_pkg::ST_CLEAR) |-> (!in_ready_o && cmd_o.op == gdr_pkg::OP_CLR))
    else $error("input or other work during map clear");
`endif

endmodule

// File: rtl/grid_dda_column_raycaster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid DDA column raycaster
// Map store plus per-column DDA ray walk giving wall distance and draw span.
// ----------------------------------------------------------------------------
// Usage: words enter on the s_axis channel. tuser selects the kind: 0 writes
// one 4-bit map cell at (cell_x, cell_y) and produces no output word; 1 casts
// the ray of screen column "column" and produces exactly one m_axis word.
// Camera position, direction and plane are set through the APB port while
// the block is idle; reads return the stored values.
// After reset the map is swept to empty, one cell per cycle, so s_axis_tready
// stays low until the sweep ends; APB writes are taken at any time.
// A map write is stored as it is accepted. A cast runs sequentially in one
// iterative unit: a hit uses five multiplies and five divisions through the
// shared 42-step restoring divider, and each DDA step is a map read, then a
// test. The DDA walk is bounded by the 66-step limit, and a ray that leaves
// the map skips the distance, line height and wall coordinate divisions.
// Only one cast is in flight; s_axis_tready rises again once its result is in
// the output register. If m_axis_tready is held low, the finished word waits
// there and a following cast holds its own result until the slot frees.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cell_x[4:0], cell_y[9:5], cell_value[13:10], column[23:14]
  input  logic [23:0] s_axis_tdata,
  // mode[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first row[8:0], last row[17:9], texture_index[21:18], hit_side[22],
  // wall_coordinate[43:23], perpendicular_distance[65:44], zero pad[71:66]
  output logic [71:0] m_axis_tdata,
  // no_hit[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW = gdr_pkg::POS_W;
  localparam int unsigned DW = gdr_pkg::DIR_W;

  // Camera registers, reset to the default view: looking down -x.
  logic [PW-1:0]        pos_x_q, pos_y_q;
  logic signed [DW-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic                 cfg_wr;
  gdr_pkg::reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = gdr_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= PW'(163840);
      pos_y_q   <= PW'(163840);
      dir_x_q   <= -DW'(65536);
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= DW'(65536);
    end else if (cfg_wr) begin
      case (cfg_idx)
        gdr_pkg::REG_POS_X:   pos_x_q   <= pwdata[PW-1:0];
        gdr_pkg::REG_POS_Y:   pos_y_q   <= pwdata[PW-1:0];
        gdr_pkg::REG_DIR_X:   dir_x_q   <= pwdata[DW-1:0];
        gdr_pkg::REG_DIR_Y:   dir_y_q   <= pwdata[DW-1:0];
        gdr_pkg::REG_PLANE_X: plane_x_q <= pwdata[DW-1:0];
        gdr_pkg::REG_PLANE_Y: plane_y_q <= pwdata[DW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Reads return the raw register bits, zero-extended.
  always_comb begin
    case (cfg_idx)
      gdr_pkg::REG_POS_X:   prdata = 32'(pos_x_q);
      gdr_pkg::REG_POS_Y:   prdata = 32'(pos_y_q);
      gdr_pkg::REG_DIR_X:   prdata = 32'(unsigned'(dir_x_q));
      gdr_pkg::REG_DIR_Y:   prdata = 32'(unsigned'(dir_y_q));
      gdr_pkg::REG_PLANE_X: prdata = 32'(unsigned'(plane_x_q));
      gdr_pkg::REG_PLANE_Y: prdata = 32'(unsigned'(plane_y_q));
      default:              prdata = '0;
    endcase
  end

  // Controller and datapath.
  gdr_pkg::dp_cmd_t  cmd;
  gdr_pkg::dp_stat_t stat;
  logic              in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  gdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .st_i       (stat)
  );

  logic [gdr_pkg::ROW_W-1:0]  span_top, span_bottom;
  logic [gdr_pkg::TEX_W-1:0]  texture_index;
  logic                       hit_side, no_hit;
  logic [PW-1:0]              wall_coordinate;
  logic [gdr_pkg::DIST_W-1:0] perpendicular_distance;

  gdr_dpath u_dpath (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cmd_i                    (cmd),
    .st_o                     (stat),
    .pos_x_i                  (pos_x_q),
    .pos_y_i                  (pos_y_q),
    .dir_x_i                  (dir_x_q),
    .dir_y_i                  (dir_y_q),
    .plane_x_i                (plane_x_q),
    .plane_y_i                (plane_y_q),
    .in_accept_i              (in_accept),
    .in_mode_i                (s_axis_tuser),
    .cell_x_i                 (s_axis_tdata[4:0]),
    .cell_y_i                 (s_axis_tdata[9:5]),
    .cell_value_i             (s_axis_tdata[13:10]),
    .column_i                 (s_axis_tdata[23:14]),
    .out_valid_o              (m_axis_tvalid),
    .out_ready_i              (m_axis_tready),
    .draw_start_o             (span_top),
    .draw_end_o               (span_bottom),
    .texture_index_o          (texture_index),
    .hit_side_o               (hit_side),
    .wall_coordinate_o        (wall_coordinate),
    .perpendicular_distance_o (perpendicular_distance),
    .no_hit_o                 (no_hit)
  );

  assign m_axis_tdata = {6'b0, perpendicular_distance, wall_coordinate, hit_side,
                         texture_index, span_bottom, span_top};
  assign m_axis_tuser = no_hit;

endmodule

// File: dv/tb_grid_dda_column_raycaster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid DDA column raycaster testbench
// Drives map writes and column casts over the stream port and camera settings
// over APB, predicts each cast by a behavioral ray walk or a typed expectation,
// and compares output words field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_grid_dda_column_raycaster;

  // Input word kinds carried on s_axis_tuser.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  localparam longint ONE_Q     = 64'sd65536;
  localparam longint DIST_SAT  = 64'sd4194303;
  localparam longint COORD_SAT = 64'sd2097151;
  localparam int     SETTLE    = 400;

  typedef struct {
    logic [8:0]  top_row;
    logic [8:0]  bottom_row;
    logic [3:0]  texture;
    logic        side;
    logic [20:0] wall;
    logic [21:0] distance;
    logic        no_hit;
  } column_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_dda_column_raycaster dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: a private copy of the map and the camera registers.
  logic [3:0]     map_model [gdr_pkg::MAP_SIZE][gdr_pkg::MAP_SIZE];
  longint         cam_reg [6];
  column_result_t pending_columns [$];
  int             errors = 0;
  bit             quiet = 1'b0;
  int             hold_request = 0;

  // Registers as signed/unsigned values; signed ones are sign extended here.
  function automatic void store_reg(gdr_pkg::reg_idx_e idx, longint value);
    longint v;
    if (idx == gdr_pkg::REG_POS_X || idx == gdr_pkg::REG_POS_Y) begin
      cam_reg[idx] = value & 64'h1FFFFF;
    end else begin
      v = value & 64'h3FFFF;
      cam_reg[idx] = (v & 64'h20000) != 0 ? v - 64'h40000 : v;
    end
  endfunction

  function automatic longint clamp_ray(longint r);
    if (r < -(64'sd1 <<< 20)) return -(64'sd1 <<< 20);
    if (r > (64'sd1 <<< 20) - 1) return (64'sd1 <<< 20) - 1;
    return r;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Distance along the ray between two grid lines of one axis.
  function automatic longint cross_step(longint r);
    if (r == 0) return 64'sd1 <<< 33;
    return (64'sd1 <<< 32) / mag(r);
  endfunction

  // floor(frac * delta / ONE) split so nothing overflows.
  function automatic longint frac_scale(longint frac, longint delta);
    return (delta >>> 16) * frac + (((delta & 64'hFFFF) * frac) >>> 16);
  endfunction

  function automatic column_result_t trace_column(logic [9:0] col);
    column_result_t res;
    longint cam, rdx, rdy, mx, my, stx, sty, ddx, ddy, sdx, sdy;
    longint num, a, b, base, off, wall, wall_dist, hl, ds, de, h, mg;
    int     n;
    bit     hit, outside, side, neg;
    logic [3:0] hit_cell;
    hit = 0;
    outside = 0;
    side = 0;
    hit_cell = '0;
    cam = ((longint'(col) * 2) <<< 16) / 1024 - ONE_Q;
    rdx = clamp_ray(cam_reg[gdr_pkg::REG_DIR_X]
                    + (cam_reg[gdr_pkg::REG_PLANE_X] * cam) / ONE_Q);
    rdy = clamp_ray(cam_reg[gdr_pkg::REG_DIR_Y]
                    + (cam_reg[gdr_pkg::REG_PLANE_Y] * cam) / ONE_Q);
    mx = cam_reg[gdr_pkg::REG_POS_X] >>> 16;
    my = cam_reg[gdr_pkg::REG_POS_Y] >>> 16;
    ddx = cross_step(rdx);
    ddy = cross_step(rdy);
    if (rdx < 0) begin
      stx = -1;
      sdx = frac_scale(cam_reg[gdr_pkg::REG_POS_X] & 64'hFFFF, ddx);
    end else begin
      stx = 1;
      sdx = frac_scale(ONE_Q - (cam_reg[gdr_pkg::REG_POS_X] & 64'hFFFF), ddx);
    end
    if (rdy < 0) begin
      sty = -1;
      sdy = frac_scale(cam_reg[gdr_pkg::REG_POS_Y] & 64'hFFFF, ddy);
    end else begin
      sty = 1;
      sdy = frac_scale(ONE_Q - (cam_reg[gdr_pkg::REG_POS_Y] & 64'hFFFF), ddy);
    end
    if (mx >= gdr_pkg::MAP_SIZE || my >= gdr_pkg::MAP_SIZE) outside = 1;
    // Walk the grid; a tie between the two side distances steps in y.
    for (n = 0; !outside && n < gdr_pkg::STEP_LIMIT; n++) begin
      if (sdx < sdy) begin
        sdx += ddx;
        mx += stx;
        side = 0;
      end else begin
        sdy += ddy;
        my += sty;
        side = 1;
      end
      if (mx < 0 || my < 0 || mx >= gdr_pkg::MAP_SIZE || my >= gdr_pkg::MAP_SIZE) begin
        outside = 1;
        break;
      end
      hit_cell = map_model[mx][my];
      if (hit_cell != 0) begin
        hit = 1;
        break;
      end
    end
    res = '{default: '0};
    res.side = side;
    if (!hit) begin
      res.distance = DIST_SAT[21:0];
      res.no_hit = 1'b1;
      return res;
    end
    if (!side) begin
      num = mx * ONE_Q - cam_reg[gdr_pkg::REG_POS_X] + (stx < 0 ? ONE_Q : 0);
      a = rdy;
      b = rdx;
      base = cam_reg[gdr_pkg::REG_POS_Y];
    end else begin
      num = my * ONE_Q - cam_reg[gdr_pkg::REG_POS_Y] + (sty < 0 ? ONE_Q : 0);
      a = rdx;
      b = rdy;
      base = cam_reg[gdr_pkg::REG_POS_X];
    end
    if (b == 0) wall_dist = DIST_SAT;
    else begin
      wall_dist = (mag(num) <<< 16) / mag(b);
      if (wall_dist > DIST_SAT) wall_dist = DIST_SAT;
    end
    // A wall right at the camera saturates the slice height.
    if (wall_dist == 0) hl = 2 * gdr_pkg::SCREEN_H;
    else begin
      h = (longint'(gdr_pkg::SCREEN_H) <<< 16) / wall_dist;
      hl = h > 2 * gdr_pkg::SCREEN_H ? 2 * gdr_pkg::SCREEN_H : h;
    end
    ds = gdr_pkg::SCREEN_H / 2 - hl / 2;
    de = hl / 2 + gdr_pkg::SCREEN_H / 2;
    if (ds < 0) ds = 0;
    if (de >= gdr_pkg::SCREEN_H) de = gdr_pkg::SCREEN_H - 1;
    if (b == 0) off = 0;
    else begin
      mg = mag(num) * mag(a) / mag(b);
      neg = ((num < 0) != (a < 0)) != (b < 0);
      off = neg ? -mg : mg;
    end
    wall = base + off;
    if (wall < 0) wall = 0;
    if (wall > COORD_SAT) wall = COORD_SAT;
    res.top_row = ds[8:0];
    res.bottom_row = de[8:0];
    res.texture = hit_cell - 4'd1;
    res.wall = wall[20:0];
    res.distance = wall_dist[21:0];
    return res;
  endfunction

  // APB write followed by a read back of the same register.
  task automatic cfg_write(gdr_pkg::reg_idx_e idx, longint value);
    logic [31:0] mask;
    mask = (idx == gdr_pkg::REG_POS_X || idx == gdr_pkg::REG_POS_Y) ?
           32'h1FFFFF : 32'h3FFFF;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 2;
    pwdata <= 32'(value) & mask;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    store_reg(idx, value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) != (32'(value) & mask)) begin
      $display("%0t reg %s read: expected %h actual %h", $time, idx.name(),
               32'(value) & mask, prdata & mask);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_all(longint px, longint py, longint dx, longint dy,
                         longint plx, longint ply);
    cfg_write(gdr_pkg::REG_POS_X, px);
    cfg_write(gdr_pkg::REG_POS_Y, py);
    cfg_write(gdr_pkg::REG_DIR_X, dx);
    cfg_write(gdr_pkg::REG_DIR_Y, dy);
    cfg_write(gdr_pkg::REG_PLANE_X, plx);
    cfg_write(gdr_pkg::REG_PLANE_Y, ply);
  endtask

  // Offer one word, wait for the handshake, then update the prediction.
  // A typed expectation replaces the predicted one for casts.
  task automatic send_word(logic mode, logic [4:0] cx, logic [4:0] cy,
                           logic [3:0] val, logic [9:0] col, bit typed,
                           column_result_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tdata <= {col, val, cy, cx};
    s_axis_tuser <= mode;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == MODE_WRITE) map_model[cx][cy] = val;
    else pending_columns.push_back(typed ? want : trace_column(col));
  endtask

  // Block is idle once every cast is back; writes finish as they are accepted.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Random map writes lean toward the border so most casts find a wall.
  task automatic random_word;
    logic [4:0] cx, cy;
    logic [3:0] val;
    if ($urandom_range(0, 99) < 55) begin
      send_word(MODE_CAST, '0, '0, '0, 10'($urandom), 0, '{default: '0});
    end else begin
      cx = 5'($urandom);
      cy = 5'($urandom);
      case ($urandom_range(0, 3))
        0: cx = '0;
        1: cx = 5'd31;
        2: cy = $urandom_range(0, 1) ? 5'd31 : 5'd0;
        default: ;
      endcase
      val = $urandom_range(0, 3) == 0 ? 4'd0 : 4'($urandom);
      send_word(MODE_WRITE, cx, cy, val, 10'($urandom), 0, '{default: '0});
    end
  endtask

  // Receiver: random stall bursts, a long hold-off on request, none when quiet.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        m_axis_tready <= 1'b0;
        hold_request--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t %s: expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Output monitor: each word is matched against the oldest expectation.
  always @(posedge clk_i) begin
    column_result_t exp_word;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_columns.size() == 0) begin
        $display("%0t unexpected output word %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_word = pending_columns.pop_front();
        check_field("top_row", exp_word.top_row, m_axis_tdata[8:0]);
        check_field("bottom_row", exp_word.bottom_row, m_axis_tdata[17:9]);
        check_field("texture_index", exp_word.texture, m_axis_tdata[21:18]);
        check_field("hit_side", exp_word.side, m_axis_tdata[22]);
        check_field("wall_coordinate", exp_word.wall, m_axis_tdata[43:23]);
        check_field("perpendicular_distance", exp_word.distance,
                    m_axis_tdata[65:44]);
        check_field("no_hit", exp_word.no_hit, m_axis_tuser);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  typedef struct {
    logic           mode;
    logic [4:0]     cx;
    logic [4:0]     cy;
    logic [3:0]     val;
    logic [9:0]     col;
    bit             typed;
    column_result_t want;
  } stim_row_t;

  // Directed rows. Reset camera sits at (2.5, 2.5) looking down -x, so the
  // center column runs straight along row 2 and its answers are easy to read.
  localparam column_result_t NONE = '{default: '0};
  stim_row_t directed [] = '{
    // empty map: the center ray leaves the map through an x side
    '{MODE_CAST, 0, 0, 0, 512, 1, '{0, 0, 0, 0, 0, 22'd4194303, 1}},
    '{MODE_CAST, 0, 0, 0, 0, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 1023, 0, NONE},
    // wall half a cell away, highest texture: full-height slice
    '{MODE_WRITE, 1, 2, 15, 0, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 512, 1, '{0, 511, 14, 0, 163840, 32768, 0}},
    '{MODE_WRITE, 1, 2, 1, 0, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 512, 1, '{0, 511, 0, 0, 163840, 32768, 0}},
    // cleared cell lets the ray reach the map edge one cell further
    '{MODE_WRITE, 1, 2, 0, 0, 0, NONE},
    '{MODE_WRITE, 0, 2, 1, 0, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 512, 1, '{86, 426, 0, 0, 163840, 98304, 0}},
    // corner cells and oblique columns
    '{MODE_WRITE, 31, 31, 15, 0, 0, NONE},
    '{MODE_WRITE, 0, 31, 7, 0, 0, NONE},
    '{MODE_WRITE, 31, 0, 3, 0, 0, NONE},
    '{MODE_WRITE, 0, 0, 8, 0, 0, NONE},
    '{MODE_WRITE, 2, 0, 5, 0, 0, NONE},
    '{MODE_WRITE, 2, 31, 10, 0, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 0, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 1, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 256, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 768, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 1023, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 682, 0, NONE},
    '{MODE_CAST, 0, 0, 0, 341, 0, NONE}
  };

  initial begin
    foreach (map_model[x, y]) map_model[x][y] = '0;
    store_reg(gdr_pkg::REG_POS_X, 163840);
    store_reg(gdr_pkg::REG_POS_Y, 163840);
    store_reg(gdr_pkg::REG_DIR_X, -65536);
    store_reg(gdr_pkg::REG_DIR_Y, 0);
    store_reg(gdr_pkg::REG_PLANE_X, 0);
    store_reg(gdr_pkg::REG_PLANE_Y, 65536);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i])
      send_word(directed[i].mode, directed[i].cx, directed[i].cy, directed[i].val,
                directed[i].col, directed[i].typed, directed[i].want);
    drain();

    for (int phase = 1; phase <= 8; phase++) begin
      case (phase)
        // Camera exactly on a grid line next to a wall: zero distance.
        1: cfg_all(131072, 163840, -65536, 0, 0, 65536);
        2: cfg_all(2097151, 2097151, 131071, 131071, 131071, 131071);
        3: cfg_all(0, 0, -131072, -131072, -131072, -131072);
        4: cfg_all(1048576, 1048576, 0, 65536, 43690, 0);
        default: begin
          if ($urandom_range(0, 1))
            cfg_all($urandom_range(65536, 2031615), $urandom_range(65536, 2031615),
                    $urandom, $urandom, $urandom, $urandom);
          else
            cfg_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
      endcase
      quiet = (phase == 8);
      if (phase == 1) send_word(MODE_WRITE, 1, 2, 9, 0, 0, NONE);
      send_word(MODE_CAST, 0, 0, 0, 512, 0, NONE);
      // The receiver holds off for a long stretch while words keep coming.
      if (phase == 4) hold_request = 3000;
      repeat (100) random_word();
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
